// ----- sv/ipl_pkg.sv -----
// ----------------------------------------------------------------------------
// Page loader package
// Shared types, bus event codes, command codes and result action codes of the
// I2C page loader command handler.
// ----------------------------------------------------------------------------
package ipl_pkg;

    localparam logic [1:0] OP_ADDR_MATCH = 2'd0;
    localparam logic [1:0] OP_RECEIVE    = 2'd1;
    localparam logic [1:0] OP_FIRST_READ = 2'd2;
    localparam logic [1:0] OP_NEXT_READ  = 2'd3;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_SEND  = 3'd1;
    localparam logic [2:0] ACT_FLASH = 3'd2;
    localparam logic [2:0] ACT_HOLD  = 3'd3;
    localparam logic [2:0] ACT_WORD  = 3'd4;
    localparam logic [2:0] ACT_QUIT  = 3'd5;

    localparam logic [7:0] CMD_PROBE      = 8'hF0;
    localparam logic [7:0] CMD_SET_PAGE   = 8'hF1;
    localparam logic [7:0] CMD_FILL       = 8'hF2;
    localparam logic [7:0] CMD_CHECKSUM   = 8'hF3;
    localparam logic [7:0] CMD_FLASH_READ = 8'hF4;
    localparam logic [7:0] CMD_QUIT       = 8'hFE;
    localparam logic [7:0] QUIT_KEY       = 8'hFF;
    localparam logic [7:0] FLASH_BURST    = 8'h10;
    localparam logic [7:0] PROBE_ANSWER   = 8'hFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } ipl_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx_byte;
        logic [15:0] flash_addr;
        logic [15:0] word_addr;
        logic [15:0] word_data;
        logic        last;
    } ipl_out_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic rd_lo;
        logic rd_hi;
        logic emit;
    } ipl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic fill;
        logic last_word;
    } ipl_stat_t;

endpackage

// ----- sv/ipl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module ipl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ipl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Page loader controller
// Sequences input capture, event execution and the word-by-word page flush.
// ----------------------------------------------------------------------------
module ipl_ctrl import ipl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ipl_stat_t stat,
    output ipl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RDLO = 3'd2;
    localparam logic [2:0] S_RDHI = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = stat.fill ? S_RDLO : S_IDLE;
                end
            end
            S_RDLO: begin
                cmd.rd_lo  = 1'b1;
                state_next = S_RDHI;
            end
            S_RDHI: begin
                cmd.rd_hi  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.last_word ? S_IDLE : S_RDLO;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/ipl_dp.sv -----
// ----------------------------------------------------------------------------
// Page loader datapath
// Command state, page buffer, checksum, flush pointer and result register.
// ----------------------------------------------------------------------------
module ipl_dp import ipl_pkg::*; #(
    parameter int PAGE_BYTES = 128
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  ipl_in_t   s_payload,
    input  ipl_cmd_t  cmd,
    output ipl_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output ipl_out_t  m_payload
);

    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int SW = $clog2(PAGE_BYTES + 1);
    localparam logic [SW-1:0] PAGE_CNT = SW'(PAGE_BYTES);
    localparam logic [SW-1:0] LAST_PTR = SW'(PAGE_BYTES - 2);
    localparam logic [SW-1:0] HI_LIMIT = SW'(PAGE_BYTES - 1);

    ipl_in_t       in_reg;
    logic [6:0]    bi_reg, bi_next, bi_bump;
    logic [7:0]    cc_reg, cc_next;
    logic [7:0]    rc_reg, rc_next;
    logic [7:0]    sum_reg, sum_next;
    logic [15:0]   pa_reg, pa_next;
    logic [SW-1:0] si_reg, si_next;
    logic [AW-1:0] fptr_reg;
    logic [7:0]    lo_reg;
    ipl_out_t      out_reg;
    logic          out_valid_reg;
    ipl_out_t      res;
    ipl_out_t      word_res;
    logic          store_ok;
    logic          fill;
    logic          hi_ok;
    logic          last_word;
    logic [AW-1:0] raddr;
    logic          re;
    logic [7:0]    rdata;
    logic [7:0]    rx;
    logic          out_free;

    assign rx       = in_reg.rx_byte;
    assign out_free = !out_valid_reg || m_ready;
    assign bi_bump  = (bi_reg == 7'h7F) ? bi_reg : bi_reg + 7'd1;

    always_comb begin
        bi_next    = bi_reg;
        cc_next    = cc_reg;
        rc_next    = rc_reg;
        sum_next   = sum_reg;
        pa_next    = pa_reg;
        si_next    = si_reg;
        store_ok   = 1'b0;
        fill       = 1'b0;
        res        = '0;
        res.last   = 1'b1;
        res.action = ACT_NONE;
        case (in_reg.operation)
            OP_ADDR_MATCH: begin
                bi_next = '0;
            end
            OP_RECEIVE: begin
                if (bi_reg == 7'd0) begin
                    cc_next = rx;
                end
                if (bi_reg == 7'd1) begin
                    rc_next = rx;
                end
                if (cc_next == CMD_SET_PAGE) begin
                    if (bi_reg == 7'd0) begin
                        si_next  = '0;
                        sum_next = '0;
                    end else if (bi_reg == 7'd2) begin
                        pa_next = {8'h00, rx};
                    end else if (bi_reg == 7'd3) begin
                        pa_next = {rx, pa_reg[7:0]};
                    end
                end
                if (cc_next == CMD_FILL && bi_reg > 7'd1 && rc_next != 8'h00 && !rc_next[7]
                    && si_reg < PAGE_CNT) begin
                    store_ok = 1'b1;
                    si_next  = si_reg + SW'(1);
                    sum_next = sum_reg + rx;
                    rc_next  = rc_next - 8'h01;
                    fill     = (si_next == PAGE_CNT);
                end
                if (!fill) begin
                    bi_next = bi_bump;
                end
                if (cc_next == CMD_QUIT && rc_next == 8'h01 && bi_reg == 7'd2
                    && rx == QUIT_KEY) begin
                    res.action = ACT_QUIT;
                end
            end
            OP_FIRST_READ: begin
                res.action = ACT_SEND;
                if (cc_reg == CMD_CHECKSUM || cc_reg == CMD_PROBE) begin
                    res.tx_byte = 8'h01;
                end else if (cc_reg == CMD_FLASH_READ) begin
                    res.tx_byte = FLASH_BURST;
                    rc_next     = 8'h00;
                end
                bi_next = bi_bump;
            end
            default: begin
                if (cc_reg == CMD_CHECKSUM) begin
                    res.action  = ACT_SEND;
                    res.tx_byte = sum_reg;
                end else if (cc_reg == CMD_PROBE) begin
                    res.action  = ACT_SEND;
                    res.tx_byte = PROBE_ANSWER;
                end else if (cc_reg == CMD_FLASH_READ) begin
                    if (rc_reg < FLASH_BURST || rc_reg[7]) begin
                        res.action     = ACT_FLASH;
                        res.flash_addr = pa_reg;
                        pa_next        = pa_reg + 16'd1;
                        rc_next        = rc_reg + 8'h01;
                    end else begin
                        res.action = ACT_HOLD;
                    end
                end else begin
                    res.action = ACT_SEND;
                end
                bi_next = bi_bump;
            end
        endcase
    end

    assign hi_ok     = SW'(fptr_reg) < HI_LIMIT;
    assign last_word = SW'(fptr_reg) >= LAST_PTR;
    assign raddr     = cmd.rd_hi ? fptr_reg + AW'(1) : fptr_reg;
    assign re        = cmd.rd_lo || (cmd.rd_hi && hi_ok);

    always_comb begin
        word_res           = '0;
        word_res.action    = ACT_WORD;
        word_res.word_addr = pa_reg + 16'(fptr_reg);
        word_res.word_data = {(hi_ok ? rdata : 8'h00), lo_reg};
        word_res.last      = last_word;
    end

    ipl_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (cmd.exec && store_ok),
        .waddr (si_reg[AW-1:0]),
        .wdata (rx),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bi_reg        <= '0;
            cc_reg        <= '0;
            rc_reg        <= '0;
            sum_reg       <= '0;
            pa_reg        <= '0;
            si_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                bi_reg  <= bi_next;
                cc_reg  <= cc_next;
                rc_reg  <= rc_next;
                sum_reg <= sum_next;
                pa_reg  <= pa_next;
                si_reg  <= si_next;
            end
            out_valid_reg <= (out_valid_reg && !m_ready) || (cmd.exec && !fill) || cmd.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_payload;
        end
        if (cmd.exec) begin
            fptr_reg <= '0;
        end else if (cmd.emit) begin
            fptr_reg <= fptr_reg + AW'(2);
        end
        if (cmd.rd_hi) begin
            lo_reg <= rdata;
        end
        if (cmd.exec && !fill) begin
            out_reg <= res;
        end else if (cmd.emit) begin
            out_reg <= word_res;
        end
    end

    always_comb begin
        stat.out_free  = out_free;
        stat.fill      = fill;
        stat.last_word = last_word;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

// ----- sv/i2c_page_loader_slave.sv -----
// ----------------------------------------------------------------------------
// I2C page loader slave command handler
// Takes one bus event word on the s_ channel (address match, received byte,
// first read, next read) and delivers its result words on the m_ channel.
// An event is registered when accepted and executed once the output register
// is free, so no new event is accepted before the last one is executed. A
// single result is loaded into the output register when the event executes.
// The byte that completes a page instead starts a flush that walks the page
// buffer through its single read port: each little-endian word is built from
// two buffer reads (low byte, then high byte) and one output load, so a page
// of PAGE_BYTES bytes yields (PAGE_BYTES+1)/2 words, the last one marked.
// The next event is accepted once the current one has been executed, even
// while its result still waits in the output register.
// When m_ready is low the output register holds its word and execution or
// the flush waits; nothing is dropped.
// Reset clears the command state, counters and output valid; the page
// buffer needs no clearing because a flush reads only bytes written since
// reset or the last set-page command.
// ----------------------------------------------------------------------------
module i2c_page_loader_slave import ipl_pkg::*; #(
    parameter int PAGE_BYTES = 128
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ipl_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output ipl_out_t m_payload
);

    ipl_cmd_t  cmd;
    ipl_stat_t stat;

    ipl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ipl_dp #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ----- tb/sv/i2c_page_loader_slave_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page loader slave testbench
// Feeds bus event words to the command handler from a queue and models
// every command in the testbench, so each result word is predicted when
// its event is accepted. Random gaps and stalls on both sides, one long
// output stall and full page flushes are used. Each result word is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_page_loader_slave_tb;
    import ipl_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int PAGE_BYTES     = 128;
    localparam int RANDOM_ITEMS   = 90;
    localparam int TAIL_ITEMS     = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int TIMEOUT_CYCLES = 1200000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ipl_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ipl_out_t m_payload;

    ipl_in_t  bus_events[$];
    ipl_out_t awaited_replies[$];
    ipl_out_t want_word;

    logic [6:0]  ld_byte_idx = '0;
    logic [7:0]  ld_cmd = '0;
    logic [7:0]  ld_count = '0;
    logic [7:0]  ld_sum = '0;
    logic [15:0] ld_page_addr = '0;
    logic [7:0]  ld_page_buf[128];
    logic [7:0]  ld_fill_idx = '0;

    logic gaps_on = 1'b1;
    logic hold_off = 1'b0;
    logic pressure_go = 1'b0;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   items_queued = 0;
    int   events_taken = 0;
    int   results_seen = 0;
    int   pages_flushed = 0;
    int   quits_seen = 0;
    int   mismatch_count = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    i2c_page_loader_slave #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    function automatic void push_reply(logic [2:0] act, logic [7:0] tx, logic [15:0] fa,
                                       logic [15:0] wa, logic [15:0] wd, logic lst);
        ipl_out_t r;
        r.action     = act;
        r.tx_byte    = tx;
        r.flash_addr = fa;
        r.word_addr  = wa;
        r.word_data  = wd;
        r.last       = lst;
        awaited_replies.push_back(r);
    endfunction

    function automatic void advance_byte_idx();
        if (ld_byte_idx != 7'd127) begin
            ld_byte_idx = ld_byte_idx + 7'd1;
        end
    endfunction

    function automatic logic count_positive();
        return ld_count != 8'd0 && !ld_count[7];
    endfunction

    function automatic logic count_below_burst();
        return ld_count < FLASH_BURST || ld_count[7];
    endfunction

    function automatic void emit_page();
        int          n;
        int          i;
        logic [7:0]  hi;
        n = (PAGE_BYTES + 1) / 2;
        for (int k = 0; k < n; k++) begin
            i  = 2 * k;
            hi = (i + 1 < PAGE_BYTES) ? ld_page_buf[(i + 1) & 127] : 8'h00;
            push_reply(ACT_WORD, 8'h00, 16'h0000, ld_page_addr + 16'(i),
                       {hi, ld_page_buf[i & 127]}, k == n - 1);
        end
    endfunction

    function automatic void take_byte(logic [7:0] rx);
        logic quit;
        if (ld_byte_idx == 7'd0) begin
            ld_cmd = rx;
        end
        if (ld_byte_idx == 7'd1) begin
            ld_count = rx;
        end
        if (ld_cmd == CMD_SET_PAGE) begin
            if (ld_byte_idx == 7'd0) begin
                ld_fill_idx = 8'd0;
                ld_sum      = 8'd0;
            end else if (ld_byte_idx == 7'd2) begin
                ld_page_addr = {8'h00, rx};
            end else if (ld_byte_idx == 7'd3) begin
                ld_page_addr = ld_page_addr | {rx, 8'h00};
            end
        end
        if (ld_cmd == CMD_FILL && ld_byte_idx > 7'd1 && count_positive()
            && ld_fill_idx < PAGE_BYTES) begin
            ld_page_buf[ld_fill_idx[6:0]] = rx;
            ld_fill_idx = ld_fill_idx + 8'd1;
            ld_sum      = ld_sum + rx;
            ld_count    = ld_count - 8'd1;
            if (ld_fill_idx == PAGE_BYTES) begin
                emit_page();
                return;
            end
        end
        quit = ld_cmd == CMD_QUIT && ld_count == 8'd1 && ld_byte_idx == 7'd2
               && rx == QUIT_KEY;
        advance_byte_idx();
        push_reply(quit ? ACT_QUIT : ACT_NONE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    endfunction

    function automatic void apply_bus_event(ipl_in_t ev);
        logic [7:0] tx;
        case (ev.operation)
            OP_ADDR_MATCH: begin
                ld_byte_idx = 7'd0;
                push_reply(ACT_NONE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
            end
            OP_RECEIVE: begin
                take_byte(ev.rx_byte);
            end
            OP_FIRST_READ: begin
                if (ld_cmd == CMD_CHECKSUM || ld_cmd == CMD_PROBE) begin
                    tx = 8'h01;
                end else if (ld_cmd == CMD_FLASH_READ) begin
                    tx       = FLASH_BURST;
                    ld_count = 8'd0;
                end else begin
                    tx = 8'h00;
                end
                advance_byte_idx();
                push_reply(ACT_SEND, tx, 16'h0000, 16'h0000, 16'h0000, 1'b1);
            end
            default: begin
                if (ld_cmd == CMD_CHECKSUM) begin
                    push_reply(ACT_SEND, ld_sum, 16'h0000, 16'h0000, 16'h0000, 1'b1);
                end else if (ld_cmd == CMD_PROBE) begin
                    push_reply(ACT_SEND, PROBE_ANSWER, 16'h0000, 16'h0000, 16'h0000, 1'b1);
                end else if (ld_cmd == CMD_FLASH_READ) begin
                    if (count_below_burst()) begin
                        push_reply(ACT_FLASH, 8'h00, ld_page_addr, 16'h0000, 16'h0000, 1'b1);
                        ld_page_addr = ld_page_addr + 16'd1;
                        ld_count     = ld_count + 8'd1;
                    end else begin
                        push_reply(ACT_HOLD, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
                    end
                end else begin
                    push_reply(ACT_SEND, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
                end
                advance_byte_idx();
            end
        endcase
    endfunction

    function automatic string fmt_word(ipl_out_t w);
        return $sformatf("act=%0d tx=%02h fa=%04h wa=%04h wd=%04h last=%0b",
                         w.action, w.tx_byte, w.flash_addr, w.word_addr, w.word_data, w.last);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_bus_event(s_payload);
                events_taken++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (bus_events.size() != 0) begin
                    s_payload <= bus_events.pop_front();
                    s_valid   <= 1'b1;
                    if (gaps_on && $urandom_range(0, 9) == 0) begin
                        src_gap <= $urandom_range(1, 10);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_payload.action == ACT_WORD && m_payload.last) begin
                    pages_flushed++;
                end
                if (m_payload.action == ACT_QUIT) begin
                    quits_seen++;
                end
                if (awaited_replies.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, actual %s",
                             $time, fmt_word(m_payload));
                end else begin
                    want_word = awaited_replies.pop_front();
                    if (m_payload !== want_word) begin
                        mismatch_count++;
                        $display("%0t: expected %s, actual %s",
                                 $time, fmt_word(want_word), fmt_word(m_payload));
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0) begin
                    sink_gap <= $urandom_range(1, 10);
                end
            end
        end
    end

    initial begin
        wait (pressure_go);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off = 1'b0;
    end

    task automatic push_event(logic [1:0] op, logic [7:0] rx);
        ipl_in_t ev;
        ev.operation = op;
        ev.rx_byte   = rx;
        bus_events.push_back(ev);
        items_queued++;
    endtask

    function automatic logic [15:0] pick_page_addr();
        if ($urandom_range(0, 3) == 0) begin
            return 16'hFFF0 + 16'($urandom_range(0, 15));
        end
        return 16'($urandom);
    endfunction

    task automatic queue_set_page(logic [15:0] base);
        push_event(OP_ADDR_MATCH, 8'($urandom));
        push_event(OP_RECEIVE, CMD_SET_PAGE);
        push_event(OP_RECEIVE, 8'($urandom));
        push_event(OP_RECEIVE, base[7:0]);
        push_event(OP_RECEIVE, base[15:8]);
    endtask

    task automatic queue_read_back(logic [7:0] cmd);
        push_event(OP_ADDR_MATCH, 8'($urandom));
        push_event(OP_RECEIVE, cmd);
        push_event(OP_FIRST_READ, 8'($urandom));
        repeat ($urandom_range(1, 3)) push_event(OP_NEXT_READ, 8'($urandom));
    endtask

    task automatic queue_page_load();
        int stored;
        int chunk;
        queue_set_page(pick_page_addr());
        stored = 0;
        while (stored < PAGE_BYTES) begin
            chunk = ($urandom_range(0, 5) == 0) ? 127 : $urandom_range(1, 40);
            push_event(OP_ADDR_MATCH, 8'($urandom));
            push_event(OP_RECEIVE, CMD_FILL);
            push_event(OP_RECEIVE, 8'(chunk));
            repeat (chunk + $urandom_range(0, 2)) push_event(OP_RECEIVE, 8'($urandom));
            stored += chunk;
        end
        queue_read_back(CMD_CHECKSUM);
    endtask

    task automatic queue_flash_read();
        if ($urandom_range(0, 1) == 0) begin
            queue_set_page(pick_page_addr());
        end
        push_event(OP_ADDR_MATCH, 8'($urandom));
        push_event(OP_RECEIVE, CMD_FLASH_READ);
        if ($urandom_range(0, 1) == 0) begin
            push_event(OP_RECEIVE, 8'($urandom));
        end
        if ($urandom_range(0, 1) == 0) begin
            push_event(OP_FIRST_READ, 8'($urandom));
        end
        repeat ($urandom_range(1, 20)) push_event(OP_NEXT_READ, 8'($urandom));
    endtask

    task automatic queue_short_fill();
        logic [7:0] cnt;
        case ($urandom_range(0, 3))
            0:       cnt = 8'($urandom_range(0, 255));
            default: cnt = 8'($urandom_range(1, 16));
        endcase
        push_event(OP_ADDR_MATCH, 8'($urandom));
        push_event(OP_RECEIVE, CMD_FILL);
        push_event(OP_RECEIVE, cnt);
        repeat ($urandom_range(0, 8)) push_event(OP_RECEIVE, 8'($urandom));
    endtask

    task automatic queue_quit();
        push_event(OP_ADDR_MATCH, 8'($urandom));
        push_event(OP_RECEIVE, CMD_QUIT);
        push_event(OP_RECEIVE, ($urandom_range(0, 3) != 0) ? 8'h01 : 8'($urandom));
        push_event(OP_RECEIVE, ($urandom_range(0, 3) != 0) ? QUIT_KEY : 8'($urandom));
        repeat ($urandom_range(0, 2)) push_event(OP_RECEIVE, 8'($urandom));
    endtask

    task automatic queue_random_mix(int target);
        items_queued = 0;
        while (items_queued < target) begin
            case ($urandom_range(0, 15))
                0:            queue_page_load();
                1, 2, 3:      queue_flash_read();
                4, 5:         queue_read_back(CMD_CHECKSUM);
                6:            queue_read_back(CMD_PROBE);
                7:            queue_quit();
                8, 9, 10, 11: queue_short_fill();
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        push_event(2'($urandom_range(0, 3)), 8'($urandom));
                    end
                end
            endcase
        end
    endtask

    task automatic wait_idle();
        while (bus_events.size() != 0 || s_valid || awaited_replies.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_event(OP_ADDR_MATCH, 8'hFF);
        push_event(OP_RECEIVE, CMD_PROBE);
        push_event(OP_FIRST_READ, 8'h00);
        push_event(OP_NEXT_READ, 8'hFF);
        push_event(OP_ADDR_MATCH, 8'h00);
        push_event(OP_RECEIVE, 8'h55);
        push_event(OP_FIRST_READ, 8'hFF);
        push_event(OP_NEXT_READ, 8'h00);
        push_event(OP_ADDR_MATCH, 8'h00);
        push_event(OP_RECEIVE, CMD_QUIT);
        push_event(OP_RECEIVE, 8'h01);
        push_event(OP_RECEIVE, QUIT_KEY);
        queue_set_page(16'hFFFF);
        push_event(OP_ADDR_MATCH, 8'h00);
        push_event(OP_RECEIVE, CMD_FLASH_READ);
        push_event(OP_RECEIVE, 8'h80);
        push_event(OP_NEXT_READ, 8'h00);
        push_event(OP_NEXT_READ, 8'hFF);
        push_event(OP_ADDR_MATCH, 8'h00);
        push_event(OP_RECEIVE, CMD_FILL);
        push_event(OP_RECEIVE, 8'hFF);
        push_event(OP_RECEIVE, 8'h00);
        queue_read_back(CMD_CHECKSUM);
        wait_idle();

        queue_page_load();
        pressure_go = 1'b1;
        wait_idle();

        queue_random_mix(RANDOM_ITEMS);
        wait_idle();

        gaps_on = 1'b0;
        queue_random_mix(TAIL_ITEMS);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);

        $display("Ran %0d bus events giving %0d result words, including %0d page flushes",
                 events_taken, results_seen, pages_flushed);
        $display("and %0d quit requests, with random gaps, stalls and one long output hold.",
                 quits_seen);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timed out with %0d words still awaited", $time, awaited_replies.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
